// ----- rtl/core/rasms_pkg.sv -----
// Package for the range add/assign/min-sum table: widths, constants and the
// controller state type. Used by every file of the block; depends on nothing.
package rasms_pkg;

  localparam int SlotCount = 32768;
  localparam int AddrW     = $clog2(SlotCount);
  localparam int SlotW     = 32;
  localparam int SumW      = 48;
  localparam int OperandW  = 16;
  localparam int CmdW      = 2;

  localparam logic [SlotW-1:0] MinEmpty = {1'b0, {(SlotW-1){1'b1}}};

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

// ----- rtl/core/rasms_slot_ram.sv -----
// Single-port-write, single-port-read slot memory with registered read data.
// Depends on rasms_pkg for depth and width.
module rasms_slot_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [rasms_pkg::AddrW-1:0]   waddr,
  input  logic [rasms_pkg::SlotW-1:0]   wdata,
  input  logic [rasms_pkg::AddrW-1:0]   raddr,
  output logic [rasms_pkg::SlotW-1:0]   rdata
);

  logic [rasms_pkg::SlotW-1:0] mem [rasms_pkg::SlotCount];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/range_add_assign_min_sum_table_core.sv -----
// Top level of the range add/assign/min-sum table.
// Depends on rasms_pkg and rasms_slot_ram.
//
//  channel | dir | tdata                               | tuser
//  in_     | in  | range_low, range_high, operand      | cmd
//  out_    | out | range_min, range_sum                | empty_range
//
// Every slot lives in one memory word. An item walks the slots of its range
// one per cycle: reads stream out of the registered memory read port, an
// update writes the modified word back the next cycle and a query folds it
// into its running minimum and sum. An empty update or the unused command
// leaves the block idle at once; an empty query goes straight to its final
// state. After reset the block clears all 32768 words, one per cycle, and
// takes no beat during that pass. One item is handled at a time; a finished
// query waits in its final state for as long as a low out_tready holds the
// previous result in the output register.
module range_add_assign_min_sum_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // range_low[14:0], range_high[29:15], operand[45:30], zero
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // range_min[31:0], range_sum[79:32]
  output logic        out_tuser   // empty_range
);

  localparam int AW = rasms_pkg::AddrW;
  localparam int SW = rasms_pkg::SlotW;
  localparam int UW = rasms_pkg::SumW;
  localparam int OW = rasms_pkg::OperandW;

  rasms_pkg::state_t state_r, state_nxt;
  rasms_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [OW-1:0]     op_r, op_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic              rd_stop_r, rd_stop_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wb_addr_r, wb_addr_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]     min_acc_r, min_acc_nxt;
  logic [UW-1:0]     sum_acc_r, sum_acc_nxt;
  logic              empty_r, empty_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     out_min_r, out_min_nxt;
  logic [UW-1:0]     out_sum_r, out_sum_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [SW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [SW-1:0]     rdata;

  logic [AW-1:0]     in_lo, in_hi;
  logic [OW-1:0]     in_op;
  logic [SW-1:0]     op_ext;
  logic              in_acc;

  assign in_lo  = in_tdata[AW-1:0];
  assign in_hi  = in_tdata[2*AW-1:AW];
  assign in_op  = in_tdata[2*AW+OW-1:2*AW];
  assign op_ext = {{(SW-OW){op_r[OW-1]}}, op_r};
  assign in_acc = in_tvalid && in_tready;

  rasms_slot_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rasms_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      rd_stop_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      rd_stop_r   <= rd_stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hi_r        <= hi_nxt;
    op_r        <= op_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wb_addr_r   <= wb_addr_nxt;
    min_acc_r   <= min_acc_nxt;
    sum_acc_r   <= sum_acc_nxt;
    empty_r     <= empty_nxt;
    out_min_r   <= out_min_nxt;
    out_sum_r   <= out_sum_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    hi_nxt        = hi_r;
    op_nxt        = op_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_stop_nxt   = rd_stop_r;
    pend_nxt      = 1'b0;
    wb_addr_nxt   = rd_ptr_r;
    clr_cnt_nxt   = clr_cnt_r;
    min_acc_nxt   = min_acc_r;
    sum_acc_nxt   = sum_acc_r;
    empty_nxt     = empty_r;
    out_min_nxt   = out_min_r;
    out_sum_nxt   = out_sum_r;
    out_empty_nxt = out_empty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    we            = 1'b0;
    waddr         = wb_addr_r;
    wdata         = '0;
    raddr         = rd_ptr_r;
    in_tready     = 1'b0;

    // Write-back, or for a query accumulation, of the word read in the previous cycle.
    if (pend_r) begin
      case (cmd_r)
        rasms_pkg::CMD_ADD: begin
          we    = 1'b1;
          wdata = rdata + op_ext;
        end
        rasms_pkg::CMD_ASSIGN: begin
          we    = 1'b1;
          wdata = op_ext;
        end
        rasms_pkg::CMD_QUERY: begin
          if ($signed(rdata) < $signed(min_acc_r)) begin
            min_acc_nxt = rdata;
          end
          sum_acc_nxt = sum_acc_r + {{(UW-SW){rdata[SW-1]}}, rdata};
        end
        default: ;
      endcase
    end

    case (state_r)
      rasms_pkg::ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {AW{1'b1}}) begin
          state_nxt = rasms_pkg::ST_IDLE;
        end
      end
      rasms_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          cmd_nxt     = rasms_pkg::cmd_t'(in_tuser);
          hi_nxt      = in_hi;
          op_nxt      = in_op;
          rd_ptr_nxt  = in_lo;
          rd_stop_nxt = 1'b0;
          min_acc_nxt = rasms_pkg::MinEmpty;
          sum_acc_nxt = '0;
          empty_nxt   = in_lo > in_hi;
          if (rasms_pkg::cmd_t'(in_tuser) == rasms_pkg::CMD_NONE) begin
            state_nxt = rasms_pkg::ST_IDLE;
          end else if (in_lo > in_hi) begin
            // Empty range: updates do nothing, a query goes straight to the final state.
            if (rasms_pkg::cmd_t'(in_tuser) == rasms_pkg::CMD_QUERY) begin
              state_nxt = rasms_pkg::ST_FIN;
            end
          end else begin
            state_nxt = rasms_pkg::ST_RUN;
          end
        end
      end
      rasms_pkg::ST_RUN: begin
        if (!rd_stop_r) begin
          pend_nxt    = 1'b1;
          wb_addr_nxt = rd_ptr_r;
          if (rd_ptr_r == hi_r) begin
            rd_stop_nxt = 1'b1;
          end else begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end
        end else if (!pend_r) begin
          state_nxt = (cmd_r == rasms_pkg::CMD_QUERY) ? rasms_pkg::ST_FIN
                                                       : rasms_pkg::ST_IDLE;
        end
      end
      rasms_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = min_acc_r;
          out_sum_nxt   = sum_acc_r;
          out_empty_nxt = empty_r;
          state_nxt     = rasms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rasms_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sum_r, out_min_r};
  assign out_tuser  = out_empty_r;

endmodule

// ----- rtl/core/rasms_chk.sv -----
// Port-level checker for range_add_assign_min_sum_table_core, with its bind.
// Depends on the top level's ports and on rasms_pkg for the command codes.
module rasms_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A query always keeps the block busy for at least the cycle after its accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == rasms_pkg::CMD_QUERY |=> !in_tready)
    else $error("second item taken before the query finished");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == {48'd0, 32'h7FFF_FFFF})
    else $error("empty query gave a wrong answer");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block active right after reset");

endmodule

bind range_add_assign_min_sum_table_core rasms_chk u_rasms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
